@@ sv/cpml_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpml_pkg
// Types and codes used by the cascaded PID motor loop.
// ----------------------------------------------------------------------------
package cpml_pkg;

    // One measurement transaction, signed Q16.16 fields.
    typedef struct packed {
        logic signed [31:0] position_meas;
        logic signed [31:0] speed_meas;
        logic signed [31:0] current_d_meas;
        logic signed [31:0] current_q_meas;
    } t_in_item;

    // One voltage command transaction, signed Q16.16 fields.
    typedef struct packed {
        logic signed [31:0] voltage_d;
        logic signed [31:0] voltage_q;
    } t_out_item;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTROL_MODE      = 3'd0,
        CFG_POSITION_TARGET   = 3'd1,
        CFG_SPEED_TARGET      = 3'd2,
        CFG_Q_CURRENT_TARGET  = 3'd3,
        CFG_D_CURRENT_TARGET  = 3'd4,
        CFG_OPEN_LOOP_VOLTAGE = 3'd5,
        CFG_TICK_PERIOD       = 3'd6,
        CFG_TICK_RATE         = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_OPEN_LOOP = 2'd0,
        MODE_CURRENT   = 2'd1,
        MODE_SPEED     = 2'd2,
        MODE_POSITION  = 2'd3
    } t_mode;

    // The code of each PID is also its slot in the integrator and error stores.
    typedef enum logic [1:0] {
        PID_D   = 2'd0,
        PID_Q   = 2'd1,
        PID_SPD = 2'd2,
        PID_POS = 2'd3
    } t_pid;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_INTEG,
        ST_DERIV_RATE,
        ST_DERIV_GAIN,
        ST_PROP,
        ST_INT_GAIN,
        ST_SUM,
        ST_OUT
    } t_state;

endpackage

@@ sv/cpml_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpml_mul
// Shared fixed-point multiplier: sign-magnitude, one 16-bit digit of the
// second operand per cycle, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module cpml_mul #(
    parameter int DW   = 32,
    parameter int BW   = 32,
    parameter int FRAC = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic                 o_done,
    output logic signed [DW-1:0] o_res
);

    localparam int DIG = 16;
    localparam int ND  = (BW + DIG - 1) / DIG;
    localparam int BPW = ND * DIG;
    localparam int PW  = DW + BPW;
    localparam int CW  = (ND > 1) ? $clog2(ND) : 1;
    localparam logic [PW:0] HALF    = (PW + 1)'(1) << (FRAC - 1);
    localparam logic [PW:0] MAG_NEG = (PW + 1)'(1) << (DW - 1);
    localparam logic [PW:0] MAG_POS = MAG_NEG - (PW + 1)'(1);

    logic [DW-1:0]     a_mag;
    logic [BW-1:0]     b_abs;
    logic [BPW-1:0]    b_mag;
    logic [DW+DIG-1:0] part;
    logic [PW-1:0]     acc_next;
    logic [PW:0]       rnd;
    logic [PW:0]       rmag;
    logic [PW:0]       maxmag;
    logic [PW:0]       sel;
    logic [DW-1:0]     res;

    logic [DW-1:0]     r_ma;
    logic [BPW-1:0]    r_mb;
    logic              r_neg;
    logic [PW-1:0]     r_acc;
    logic [CW-1:0]     r_cnt;
    logic              r_run;
    logic              r_rnd;
    logic              r_done;
    logic signed [DW-1:0] r_res;

    always_comb begin
        a_mag    = i_a[DW-1] ? (~i_a + 1'b1) : i_a;
        b_abs    = i_b[BW-1] ? (~i_b + 1'b1) : i_b;
        b_mag    = BPW'(b_abs);
        part     = r_ma * r_mb[BPW-1 -: DIG];
        acc_next = {r_acc[PW-DIG-1:0], {DIG{1'b0}}} + PW'(part);
        rnd      = {1'b0, r_acc} + HALF;
        rmag     = rnd >> FRAC;
        maxmag   = r_neg ? MAG_NEG : MAG_POS;
        sel      = (rmag > maxmag) ? maxmag : rmag;
        res      = r_neg ? (~sel[DW-1:0] + 1'b1) : sel[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_rnd  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma  <= a_mag;
                r_mb  <= b_mag;
                r_neg <= i_a[DW-1] ^ i_b[BW-1];
                r_acc <= '0;
                r_cnt <= CW'(ND - 1);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_acc <= acc_next;
                r_mb  <= r_mb << DIG;
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                    r_rnd <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (r_rnd) begin
                r_rnd  <= 1'b0;
                r_done <= 1'b1;
                r_res  <= res;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ sv/cascaded_pid_motor_loop.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_pid_motor_loop
// Position, speed and d/q current PID cascade with clamped integrators.
// ----------------------------------------------------------------------------
// Each measurement transaction produces one d/q voltage transaction. The
// control mode picks how many PIDs run: current mode runs the d and q
// current PIDs, speed mode runs the speed PID first, position mode the
// position PID before that. All PIDs share one multiplier that takes one
// 16-bit digit per cycle, over ND = ceil(max(DATA_WIDTH, 32) / 16) digits,
// and each PID takes five multiplies plus an error state and a sum state;
// open loop runs no PID. The input is stalled while a transaction is
// worked on; a finished result waits in the output register without
// blocking the next input. Configuration writes take effect at once and
// belong to idle periods.
// ----------------------------------------------------------------------------
module cascaded_pid_motor_loop #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cpml_pkg::t_in_item                   i_in,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    output cpml_pkg::t_out_item                  o_out,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_cfg_we,
    input  logic [cpml_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cpml_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import cpml_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int XW = (DW > 32) ? DW : 32;

    localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
    localparam longint DMAX_L = (64'sd1 <<< (DW - 1)) - 64'sd1;

    localparam logic signed [XW-1:0] DMAX_X = {{(XW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [XW-1:0] DMIN_X = ~DMAX_X;
    localparam logic signed [DW-1:0] DMAX   = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN   = ~DMAX;

    // Gains rounded to the nearest fraction step.
    localparam logic signed [XW-1:0] KP_CUR = XW'((ONE_L + 64'sd1) / 2);
    localparam logic signed [XW-1:0] KI_CUR = XW'((ONE_L + 64'sd5) / 10);
    localparam logic signed [XW-1:0] KD_CUR = '0;
    localparam logic signed [XW-1:0] KP_SPD = XW'((ONE_L + 64'sd5) / 10);
    localparam logic signed [XW-1:0] KI_SPD = XW'((ONE_L + 64'sd50) / 100);
    localparam logic signed [XW-1:0] KD_SPD = XW'((ONE_L + 64'sd500) / 1000);
    localparam logic signed [XW-1:0] KP_POS = XW'(ONE_L);
    localparam logic signed [XW-1:0] KI_POS = '0;
    localparam logic signed [XW-1:0] KD_POS = XW'((ONE_L + 64'sd50) / 100);

    localparam longint LIM_CUR_L = (ONE_L + 64'sd2) / 4;
    localparam longint LIM_SPD_L = ONE_L;
    localparam longint LIM_POS_L = 64'sd10 * ONE_L;
    localparam longint VQ_OPEN_L = (ONE_L + 64'sd5) / 10;

    localparam logic signed [DW-1:0] LIM_CUR =
        DW'((LIM_CUR_L > DMAX_L) ? DMAX_L : LIM_CUR_L);
    localparam logic signed [DW-1:0] LIM_SPD =
        DW'((LIM_SPD_L > DMAX_L) ? DMAX_L : LIM_SPD_L);
    localparam logic signed [DW-1:0] LIM_POS =
        DW'((LIM_POS_L > DMAX_L) ? DMAX_L : LIM_POS_L);
    localparam logic signed [DW-1:0] VQ_OPEN =
        DW'((VQ_OPEN_L > DMAX_L) ? DMAX_L : VQ_OPEN_L);

    function automatic logic signed [DW-1:0] sat32(input logic signed [31:0] v);
        logic signed [XW-1:0] ext;
        ext = XW'(v);
        if (ext > DMAX_X) begin
            return DMAX;
        end else if (ext < DMIN_X) begin
            return DMIN;
        end
        return ext[DW-1:0];
    endfunction

    function automatic logic signed [31:0] to32(input logic signed [DW-1:0] v);
        logic signed [XW-1:0] ext;
        ext = XW'(v);
        return ext[31:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? DMIN : DMAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? DMIN : DMAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] v,
                                                   input logic signed [DW-1:0] lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Configuration registers
    t_mode              r_mode;
    logic signed [31:0] r_pos_tgt;
    logic signed [31:0] r_spd_tgt;
    logic signed [31:0] r_q_tgt;
    logic signed [31:0] r_d_tgt;
    logic signed [31:0] r_open_v;
    logic [15:0]        r_tick_period;
    logic [30:0]        r_tick_rate;

    // Sequencer and datapath
    t_state               r_state;
    t_state               n_state;
    t_pid                 r_stage;
    logic                 r_issued;
    logic signed [DW-1:0] r_pos_m;
    logic signed [DW-1:0] r_spd_m;
    logic signed [DW-1:0] r_id_m;
    logic signed [DW-1:0] r_iq_m;
    logic signed [DW-1:0] r_pos_sp;
    logic signed [DW-1:0] r_spd_sp;
    logic signed [DW-1:0] r_q_sp;
    logic signed [DW-1:0] r_d_sp;
    logic signed [DW-1:0] r_vd;
    logic signed [DW-1:0] r_vq;
    logic signed [DW-1:0] r_e;
    logic signed [DW-1:0] r_ediff;
    logic signed [DW-1:0] r_d;
    logic signed [DW-1:0] r_acc;
    logic signed [DW-1:0] r_integ [4];
    logic signed [DW-1:0] r_lerr  [4];

    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 in_acc;
    logic                 out_load;
    logic                 mul_state;
    logic                 mul_start;
    logic                 mul_done;
    logic signed [DW-1:0] mul_a;
    logic signed [XW-1:0] mul_b;
    logic signed [DW-1:0] mul_res;
    logic signed [XW-1:0] g_kp;
    logic signed [XW-1:0] g_ki;
    logic signed [XW-1:0] g_kd;
    logic signed [DW-1:0] g_lim;
    logic signed [DW-1:0] g_sp;
    logic signed [DW-1:0] g_meas;
    logic signed [DW-1:0] integ_new;
    logic signed [DW-1:0] pid_out;
    logic signed [XW-1:0] tp_op;
    logic signed [XW-1:0] tr_op;

    assign tp_op = XW'({1'b0, r_tick_period});
    assign tr_op = XW'({1'b0, r_tick_rate});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OPEN_LOOP;
            r_pos_tgt     <= '0;
            r_spd_tgt     <= '0;
            r_q_tgt       <= 32'sd13107;
            r_d_tgt       <= 32'sd6554;
            r_open_v      <= 32'sd16384;
            r_tick_period <= 16'd66;
            r_tick_rate   <= 31'd65536000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CONTROL_MODE:      r_mode        <= t_mode'(i_cfg_data[1:0]);
                CFG_POSITION_TARGET:   r_pos_tgt     <= i_cfg_data;
                CFG_SPEED_TARGET:      r_spd_tgt     <= i_cfg_data;
                CFG_Q_CURRENT_TARGET:  r_q_tgt       <= i_cfg_data;
                CFG_D_CURRENT_TARGET:  r_d_tgt       <= i_cfg_data;
                CFG_OPEN_LOOP_VOLTAGE: r_open_v      <= i_cfg_data;
                CFG_TICK_PERIOD:       r_tick_period <= i_cfg_data[15:0];
                CFG_TICK_RATE:         r_tick_rate   <= i_cfg_data[30:0];
            endcase
        end
    end

    // Gains, limit, setpoint and measurement of the PID being worked on.
    always_comb begin
        unique case (r_stage)
            PID_D: begin
                g_kp = KP_CUR;  g_ki = KI_CUR;  g_kd = KD_CUR;  g_lim = LIM_CUR;
                g_sp = r_d_sp;  g_meas = r_id_m;
            end
            PID_Q: begin
                g_kp = KP_CUR;  g_ki = KI_CUR;  g_kd = KD_CUR;  g_lim = LIM_CUR;
                g_sp = r_q_sp;  g_meas = r_iq_m;
            end
            PID_SPD: begin
                g_kp = KP_SPD;  g_ki = KI_SPD;  g_kd = KD_SPD;  g_lim = LIM_SPD;
                g_sp = r_spd_sp;  g_meas = r_spd_m;
            end
            PID_POS: begin
                g_kp = KP_POS;  g_ki = KI_POS;  g_kd = KD_POS;  g_lim = LIM_POS;
                g_sp = r_pos_sp;  g_meas = r_pos_m;
            end
        endcase
    end

    assign integ_new = clamp(sat_add(r_integ[r_stage], mul_res), g_lim);
    assign pid_out   = clamp(sat_add(r_acc, r_d), g_lim);

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_state = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (r_mode == MODE_OPEN_LOOP) ? ST_OUT : ST_ERR;
                end
            end
            ST_ERR: begin
                n_state = ST_INTEG;
            end
            ST_INTEG: begin
                mul_state = 1'b1;
                mul_a     = r_e;
                mul_b     = tp_op;
                if (mul_done) n_state = ST_DERIV_RATE;
            end
            ST_DERIV_RATE: begin
                mul_state = 1'b1;
                mul_a     = r_ediff;
                mul_b     = tr_op;
                if (mul_done) n_state = ST_DERIV_GAIN;
            end
            ST_DERIV_GAIN: begin
                mul_state = 1'b1;
                mul_a     = r_d;
                mul_b     = g_kd;
                if (mul_done) n_state = ST_PROP;
            end
            ST_PROP: begin
                mul_state = 1'b1;
                mul_a     = r_e;
                mul_b     = g_kp;
                if (mul_done) n_state = ST_INT_GAIN;
            end
            ST_INT_GAIN: begin
                mul_state = 1'b1;
                mul_a     = r_integ[r_stage];
                mul_b     = g_ki;
                if (mul_done) n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = (r_stage == PID_Q) ? ST_OUT : ST_ERR;
            end
            ST_OUT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign mul_start = mul_state && !r_issued;

    cpml_mul #(
        .DW   (DW),
        .BW   (XW),
        .FRAC (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued <= 1'b0;
            r_stage  <= PID_D;
            for (int k = 0; k < 4; k++) begin
                r_integ[k] <= '0;
                r_lerr[k]  <= '0;
            end
        end else begin
            if (mul_start) begin
                r_issued <= 1'b1;
            end else if (mul_done) begin
                r_issued <= 1'b0;
            end

            if (in_acc) begin
                r_pos_m  <= sat32(i_in.position_meas);
                r_spd_m  <= sat32(i_in.speed_meas);
                r_id_m   <= sat32(i_in.current_d_meas);
                r_iq_m   <= sat32(i_in.current_q_meas);
                r_pos_sp <= sat32(r_pos_tgt);
                r_spd_sp <= sat32(r_spd_tgt);
                r_q_sp   <= sat32(r_q_tgt);
                r_d_sp   <= sat32(r_d_tgt);
                r_vd     <= sat32(r_open_v);
                r_vq     <= VQ_OPEN;
                unique case (r_mode)
                    MODE_POSITION:  r_stage <= PID_POS;
                    MODE_SPEED:     r_stage <= PID_SPD;
                    MODE_CURRENT:   r_stage <= PID_D;
                    MODE_OPEN_LOOP: r_stage <= PID_D;
                endcase
            end

            unique case (r_state)
                ST_ERR: begin
                    r_e <= sat_sub(g_sp, g_meas);
                end
                ST_INTEG: begin
                    if (mul_done) begin
                        r_integ[r_stage] <= integ_new;
                        r_ediff          <= sat_sub(r_e, r_lerr[r_stage]);
                    end
                end
                ST_DERIV_RATE, ST_DERIV_GAIN: begin
                    if (mul_done) r_d <= mul_res;
                end
                ST_PROP: begin
                    if (mul_done) r_acc <= mul_res;
                end
                ST_INT_GAIN: begin
                    if (mul_done) r_acc <= sat_add(r_acc, mul_res);
                end
                ST_SUM: begin
                    r_lerr[r_stage] <= r_e;
                    // Cascaded targets live only for this transaction.
                    unique case (r_stage)
                        PID_POS: begin
                            r_spd_sp <= pid_out;
                            r_stage  <= PID_SPD;
                        end
                        PID_SPD: begin
                            r_q_sp  <= pid_out;
                            r_d_sp  <= '0;
                            r_stage <= PID_D;
                        end
                        PID_D: begin
                            r_vd    <= pid_out;
                            r_stage <= PID_Q;
                        end
                        PID_Q: begin
                            r_vq <= pid_out;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.voltage_d <= to32(r_vd);
            r_out.voltage_q <= to32(r_vq);
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
